FILE: rtl/mwa_pkg.sv
`timescale 1ns / 1ps

package mwa_pkg;

  // Fixed field widths of the external words
  localparam int WIN_W      = 5;
  localparam int CHAN_OUT_W = 3;
  localparam int SMP_IO_W   = 12;

  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  // Parameter defaults
  localparam int DEF_CHANNELS    = 5;
  localparam int DEF_WINDOW_MAX  = 16;
  localparam int DEF_SAMPLE_BITS = 12;

  // Controller -> datapath
  typedef struct packed {
    logic cfg_wr;    // take window register, clear ring indices and full flags
    logic accept;    // take input word, write ring slot
    logic read;      // issue one ring read
    logic div_step;  // one restoring divide step
    logic out_load;  // load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic read_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/multichannel_window_average.sv
`timescale 1ns / 1ps
// Per word: accept, ring read of the count slots averaged at one slot per cycle, RAM drain,
//   restoring divide at one bit per cycle over SUM_W = SAMPLE_BITS + clog2(WINDOW_MAX+1) steps
//   (17 by default), then output load, which waits while the output register is still held.
//   A new input word is taken only after the previous word's result is loaded.
// Reset (rst_n, sync, active low): turn pointer, ring indices and full flags cleared,
//   window length 16; ring contents are never read before being written, so need no clear.
module multichannel_window_average #(
  parameter int CHANNELS    = mwa_pkg::DEF_CHANNELS,
  parameter int WINDOW_MAX  = mwa_pkg::DEF_WINDOW_MAX,
  parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input word channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mwa_pkg::SMP_IO_W-1:0]   in_sample,
  // result word channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mwa_pkg::CHAN_OUT_W-1:0] out_channel,
  output logic [mwa_pkg::SMP_IO_W-1:0]   out_raw_value,
  output logic [mwa_pkg::SMP_IO_W-1:0]   out_mean_value,
  output logic                           out_window_full,
  // window length register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mwa_pkg::WIN_W-1:0]      cfg_window_length
);

  import mwa_pkg::*;

  // Flow per word:
  //   IDLE  : accept, write sample at channel's ring slot, bump index/full flag
  //   READ  : stream slots 0..count-1 out of the ring RAM into the sum
  //   DRAIN : last RAM word lands
  //   DIV   : restoring divide, one quotient bit per cycle, sum / count
  //   DONE  : park until output register is free, then load it
  // The output register frees the controller: the next word is taken while a
  // result still waits downstream.
  // A window register write is taken only in IDLE and clears indices and
  // full flags; the turn pointer keeps going.

  cmd_t cmd;
  sts_t sts;

  mwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwa_datapath #(
    .CHANNELS    (CHANNELS),
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .out_raw_value     (out_raw_value),
    .out_mean_value    (out_mean_value),
    .out_window_full   (out_window_full)
  );

  // One word in flight: an accept is followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous word in flight");

  // Config write and input accept never share an edge.
  a_cfg_vs_in: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready && in_valid && !in_stall))
    else $error("config write collided with input accept");

  // Controller issues at most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cfg_wr, cmd.accept, cmd.read, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");

  // A taken result with no new load leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !cmd.out_load) |=> !out_valid)
    else $error("result word repeated");

  // Loading a result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

endmodule

FILE: rtl/mwa_ram.sv
`timescale 1ns / 1ps

module mwa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 80,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mwa_ctrl.sv
`timescale 1ns / 1ps

module mwa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  mwa_pkg::sts_t sts,
  output mwa_pkg::cmd_t cmd
);

  import mwa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;  // config write wins
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (sts.read_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIV;  // last read word lands in the sum
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mwa_datapath.sv
`timescale 1ns / 1ps

module mwa_datapath #(
  parameter int CHANNELS    = mwa_pkg::DEF_CHANNELS,
  parameter int WINDOW_MAX  = mwa_pkg::DEF_WINDOW_MAX,
  parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwa_pkg::cmd_t                 cmd,
  output mwa_pkg::sts_t                 sts,
  input  logic [mwa_pkg::WIN_W-1:0]     cfg_window_length,
  input  logic [mwa_pkg::SMP_IO_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mwa_pkg::CHAN_OUT_W-1:0] out_channel,
  output logic [mwa_pkg::SMP_IO_W-1:0]  out_raw_value,
  output logic [mwa_pkg::SMP_IO_W-1:0]  out_mean_value,
  output logic                          out_window_full
);

  import mwa_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (LEN_W > WIN_W) ? LEN_W : WIN_W;
  localparam int SUM_W  = SAMPLE_BITS + LEN_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int DEPTH  = CHANNELS * (2 ** IDX_W);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CMP_W-1:0]  WMAX_C   = CMP_W'(WINDOW_MAX);
  localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(SUM_W - 1);

  logic [WIN_W-1:0]       win_r;
  logic [CH_W-1:0]        turn_r;
  logic [IDX_W-1:0]       widx_r [CHANNELS];
  logic [CHANNELS-1:0]    full_r;

  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   wfull_r;
  logic [LEN_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       rdk_r;
  logic                   rdpend_r;
  logic [SUM_W-1:0]       acc_r;
  logic [LEN_W-1:0]       rem_r;
  logic [STEP_W-1:0]      step_r;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic [SAMPLE_BITS-1:0] out_raw_r;
  logic [SAMPLE_BITS-1:0] out_mean_r;
  logic                   out_full_r;

  logic [LEN_W-1:0]       eff_len;
  logic [SAMPLE_BITS-1:0] smp_in;
  logic [IDX_W-1:0]       idx;
  logic [LEN_W-1:0]       idx_p1;
  logic                   wrap;
  logic                   full_now;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [LEN_W:0]         trial;
  logic                   qbit;
  logic [LEN_W-1:0]       rem_nxt;

  // Clamp window length into 1..WINDOW_MAX
  always_comb begin
    if (win_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (CMP_W'(win_r) > WMAX_C) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(win_r);
    end
  end

  assign smp_in = SAMPLE_BITS'(in_sample);

  always_comb begin
    idx = widx_r[turn_r];
    if (LEN_W'(idx) >= eff_len) begin
      idx = '0;
    end
    idx_p1   = LEN_W'(idx) + LEN_W'(1);
    wrap     = (idx_p1 >= eff_len);
    full_now = full_r[turn_r] | wrap;
  end

  assign waddr = ADDR_W'({turn_r, idx});
  assign raddr = ADDR_W'({ch_r, rdk_r});

  mwa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (waddr),
    .wdata (smp_in),
    .re    (cmd.read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Restoring divide step, quotient shifts into acc_r
  always_comb begin
    trial = {rem_r, acc_r[SUM_W-1]};
    qbit  = (trial >= {1'b0, cnt_r});
    if (qbit) begin
      rem_nxt = LEN_W'(trial - {1'b0, cnt_r});
    end else begin
      rem_nxt = trial[LEN_W-1:0];
    end
  end

  // Ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      turn_r <= '0;
      full_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        widx_r[c] <= '0;
      end
    end else if (cmd.cfg_wr) begin
      win_r  <= cfg_window_length;
      full_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        widx_r[c] <= '0;
      end
    end else if (cmd.accept) begin
      widx_r[turn_r] <= wrap ? '0 : IDX_W'(idx_p1);
      if (wrap) begin
        full_r[turn_r] <= 1'b1;
      end
      turn_r <= (turn_r == CH_LAST) ? '0 : turn_r + CH_W'(1);
    end
  end

  // Per-word work registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdpend_r <= 1'b0;
    end else begin
      rdpend_r <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r    <= turn_r;
      smp_r   <= smp_in;
      wfull_r <= full_now;
      cnt_r   <= full_now ? eff_len : idx_p1;
      rdk_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      step_r  <= '0;
    end else begin
      if (cmd.read) begin
        rdk_r <= rdk_r + IDX_W'(1);
      end
      if (rdpend_r) begin
        acc_r <= acc_r + SUM_W'(rdata);
      end else if (cmd.div_step) begin
        acc_r  <= {acc_r[SUM_W-2:0], qbit};
        rem_r  <= rem_nxt;
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_raw_r  <= smp_r;
      out_mean_r <= SAMPLE_BITS'(acc_r);
      out_full_r <= wfull_r;
    end
  end

  assign sts.read_last = (LEN_W'(rdk_r) == cnt_r - LEN_W'(1));
  assign sts.div_last  = (step_r == STEP_END);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_channel     = CHAN_OUT_W'(out_ch_r);
  assign out_raw_value   = SMP_IO_W'(out_raw_r);
  assign out_mean_value  = SMP_IO_W'(out_mean_r);
  assign out_window_full = out_full_r;

endmodule
